>>> design/pi_position_controller_assert.svh
// ----------------------------------------------------------------------------
// pi_position_controller_assert.svh
// Assertion macros shared by the position controller RTL.
// ----------------------------------------------------------------------------
`ifndef PI_POSITION_CONTROLLER_ASSERT_SVH
`define PI_POSITION_CONTROLLER_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define PIPC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequent in the cycle after an antecedent.
`define PIPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pipc_pkg.sv
// ----------------------------------------------------------------------------
// pipc_pkg
// Widths, register map and reset values of the PI position controller.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int ANGLE_W   = 10;
    localparam int ERR_W     = 11;
    localparam int MAG_W     = 10;
    localparam int TOL_W     = 10;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 7;
    localparam int DWELL_W   = 16;
    localparam int DRIVE_W   = 8;
    localparam int PROD_W    = GAIN_W + MAG_W;
    localparam int PTERM_W   = PROD_W + 1;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int INTEGRAL_WIDTH_DEF = 24;

    localparam logic [ANGLE_W-1:0] TARGET_RST  = 10'sd0;
    localparam logic [TOL_W-1:0]   TOL_RST     = 10'd2;
    localparam logic [GAIN_W-1:0]  KP_RST      = 16'd256;
    localparam logic [GAIN_W-1:0]  KI_RST      = 16'd77;
    localparam logic [LIM_W-1:0]   FLOOR_RST   = 7'd1;
    localparam logic [LIM_W-1:0]   CEIL_RST    = 7'd125;
    localparam logic [DWELL_W-1:0] DWELL_RST   = 16'd40;

    typedef enum logic [2:0] {
        REG_TARGET  = 3'd0,
        REG_TOL     = 3'd1,
        REG_KP      = 3'd2,
        REG_KI      = 3'd3,
        REG_FLOOR   = 3'd4,
        REG_CEIL    = 3'd5,
        REG_DWELL   = 3'd6
    } t_reg_idx;

endpackage

>>> design/pi_position_controller.sv
// ----------------------------------------------------------------------------
// pi_position_controller
// PI position controller with conditional integration, dwell-based settle
// detection and sign-dependent drive clamping.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+--------------------------
//  in        | in        | i_in_valid / o_in_stall       | i_measured_angle, i_restart
//  out       | out       | o_out_valid / i_out_stall     | o_drive, o_error_out, o_settled
//  cfg (APB) | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One beat per cycle sustained while the output is not stalled; a result passes
//  the input, error, state, integral-product and output registers in turn.
//  The integral, dwell and settle state update together in the state stage.
//  Synchronous active-low reset clears valid bits and state and reloads config defaults.
//  A stalled output holds its beat; bubbles in the pipe still close up.
// ----------------------------------------------------------------------------
`include "pi_position_controller_assert.svh"

module pi_position_controller #(
    parameter int INTEGRAL_WIDTH = pipc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [pipc_pkg::ANGLE_W-1:0] i_measured_angle,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pipc_pkg::DRIVE_W-1:0] o_drive,
    output logic signed [pipc_pkg::ERR_W-1:0]   o_error_out,
    output logic                                o_settled,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [pipc_pkg::ADDR_W-1:0]  paddr,
    input  logic        [pipc_pkg::DATA_W-1:0]  pwdata,
    output logic        [pipc_pkg::DATA_W-1:0]  prdata,
    output logic                                pready
);
    import pipc_pkg::*;

    localparam int IW      = INTEGRAL_WIDTH;
    localparam int IPROD_W = GAIN_W + 1 + IW;
    localparam int SUM_W   = IPROD_W + 1;

    localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

    // configuration registers
    logic signed [ANGLE_W-1:0] r_target;
    logic [TOL_W-1:0]          r_tol;
    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_ki;
    logic [LIM_W-1:0]          r_floor;
    logic [LIM_W-1:0]          r_ceil;
    logic [DWELL_W-1:0]        r_dwell_req;

    // controller state
    logic signed [IW-1:0]      r_integ;
    logic [DWELL_W-1:0]        r_dwell;
    logic                      r_settled;

    // pipeline valids
    logic r_v1, r_v2, r_v3, r_v4, r_ov;

    // pipeline payload
    logic signed [ANGLE_W-1:0] r_s1_meas;
    logic                      r_s1_restart;
    logic signed [ERR_W-1:0]   r_s2_err;
    logic [MAG_W-1:0]          r_s2_mag;
    logic [PROD_W-1:0]         r_s2_prod;
    logic                      r_s2_restart;
    logic signed [ERR_W-1:0]   r_s3_err;
    logic signed [PTERM_W-1:0] r_s3_pterm;
    logic signed [IW-1:0]      r_s3_integ;
    logic                      r_s3_active;
    logic                      r_s3_settled;
    logic signed [ERR_W-1:0]   r_s4_err;
    logic signed [PTERM_W-1:0] r_s4_pterm;
    logic signed [IPROD_W-1:0] r_s4_iprod;
    logic                      r_s4_active;
    logic                      r_s4_settled;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic signed [ERR_W-1:0]   r_out_err;
    logic                      r_out_settled;

    // handshake
    logic out_free, load_out, free4, load4, free3, load3, free2, load2, free1;
    logic cfg_wr;

    assign out_free   = !r_ov || !i_out_stall;
    assign load_out   = r_v4 && out_free;
    assign free4      = !r_v4 || load_out;
    assign load4      = r_v3 && free4;
    assign free3      = !r_v3 || load4;
    assign load3      = r_v2 && free3;
    assign free2      = !r_v2 || load3;
    assign load2      = r_v1 && free2;
    assign free1      = !r_v1 || load2;
    assign o_in_stall = !free1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // stage 1 -> 2: error and gain-scaled magnitude
    logic signed [ERR_W-1:0] n_err;
    logic [ERR_W-1:0]        n_abs;
    logic [MAG_W-1:0]        n_mag;
    logic [PROD_W-1:0]       n_prod;

    always_comb begin
        n_err  = {r_target[ANGLE_W-1], r_target} - {r_s1_meas[ANGLE_W-1], r_s1_meas};
        n_abs  = n_err[ERR_W-1] ? ERR_W'(-n_err) : n_err;
        n_mag  = n_abs[MAG_W-1:0];
        n_prod = PROD_W'(r_kp) * PROD_W'(n_mag);
    end

    // stage 2 -> 3: window, state update
    logic                      n_window;
    logic signed [PTERM_W-1:0] n_pterm;
    logic signed [IW-1:0]      n_integ0, n_integ1;
    logic signed [IW:0]        n_isum;
    logic [DWELL_W-1:0]        n_dwell0, n_dwell1;
    logic                      n_settled0, n_settled1, n_active;

    always_comb begin
        n_window   = r_s2_prod < PROD_W'({r_ceil, 8'h00});
        n_pterm    = r_s2_err[ERR_W-1] ? -$signed({1'b0, r_s2_prod})
                                       : $signed({1'b0, r_s2_prod});
        n_integ0   = r_s2_restart ? '0 : r_integ;
        n_dwell0   = r_s2_restart ? '0 : r_dwell;
        n_settled0 = r_s2_restart ? 1'b0 : r_settled;
        n_active   = !n_settled0;
        n_isum     = {n_integ0[IW-1], n_integ0}
                   + {{(IW+1-ERR_W){r_s2_err[ERR_W-1]}}, r_s2_err};
        n_integ1   = n_integ0;
        n_dwell1   = n_dwell0;
        n_settled1 = n_settled0;
        if (n_active) begin
            if (n_window) begin
                if (n_isum[IW] != n_isum[IW-1]) begin
                    n_integ1 = n_isum[IW] ? IMIN : IMAX;
                end else begin
                    n_integ1 = n_isum[IW-1:0];
                end
            end
            if ((r_s2_mag < r_tol) && (n_dwell0 != '1)) begin
                n_dwell1 = n_dwell0 + DWELL_W'(1);
            end
            n_settled1 = (r_s2_mag <= r_tol) && (n_dwell1 >= r_dwell_req);
        end
    end

    // stage 3 -> 4: integral term
    logic signed [GAIN_W:0]    n_ki_s;
    logic signed [IPROD_W-1:0] n_iprod;

    always_comb begin
        n_ki_s  = {1'b0, r_ki};
        n_iprod = IPROD_W'(n_ki_s) * IPROD_W'(r_s3_integ);
    end

    // stage 4 -> out: sum, scale toward zero, clamp, zero drive while settled
    logic signed [SUM_W-1:0] n_sum, n_biased, n_raw, n_lo, n_hi, n_clip;
    logic signed [LIM_W+1:0] n_lo9, n_hi9;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        n_sum    = {{(SUM_W-PTERM_W){r_s4_pterm[PTERM_W-1]}}, r_s4_pterm}
                 + {r_s4_iprod[IPROD_W-1], r_s4_iprod};
        n_biased = n_sum + (n_sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        n_raw    = n_biased >>> 8;
        if (r_s4_err > 0) begin
            n_lo9 = {2'b00, r_floor};
            n_hi9 = {2'b00, r_ceil};
        end else if (r_s4_err < 0) begin
            n_lo9 = -$signed({2'b00, r_ceil});
            n_hi9 = -$signed({2'b00, r_floor});
        end else begin
            n_lo9 = -9'sd128;
            n_hi9 = 9'sd127;
        end
        n_lo   = {{(SUM_W-LIM_W-2){n_lo9[LIM_W+1]}}, n_lo9};
        n_hi   = {{(SUM_W-LIM_W-2){n_hi9[LIM_W+1]}}, n_hi9};
        n_clip = n_raw;
        if (n_clip < n_lo) begin
            n_clip = n_lo;
        end
        if (n_clip > n_hi) begin
            n_clip = n_hi;
        end
        n_drive = r_s4_active ? n_clip[DRIVE_W-1:0] : '0;
    end

    // control, state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_ov        <= 1'b0;
            r_integ     <= '0;
            r_dwell     <= '0;
            r_settled   <= 1'b0;
            r_target    <= TARGET_RST;
            r_tol       <= TOL_RST;
            r_kp        <= KP_RST;
            r_ki        <= KI_RST;
            r_floor     <= FLOOR_RST;
            r_ceil      <= CEIL_RST;
            r_dwell_req <= DWELL_RST;
        end else begin
            if (free1)    r_v1 <= i_in_valid;
            if (free2)    r_v2 <= r_v1;
            if (free3)    r_v3 <= r_v2;
            if (free4)    r_v4 <= r_v3;
            if (out_free) r_ov <= r_v4;
            if (load3) begin
                r_integ   <= n_integ1;
                r_dwell   <= n_dwell1;
                r_settled <= n_settled1;
            end
            if (cfg_wr) begin
                unique case (paddr[ADDR_W-1:2])
                    REG_TARGET: r_target    <= pwdata[ANGLE_W-1:0];
                    REG_TOL:    r_tol       <= pwdata[TOL_W-1:0];
                    REG_KP:     r_kp        <= pwdata[GAIN_W-1:0];
                    REG_KI:     r_ki        <= pwdata[GAIN_W-1:0];
                    REG_FLOOR:  r_floor     <= pwdata[LIM_W-1:0];
                    REG_CEIL:   r_ceil      <= pwdata[LIM_W-1:0];
                    REG_DWELL:  r_dwell_req <= pwdata[DWELL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (free1 && i_in_valid) begin
            r_s1_meas    <= i_measured_angle;
            r_s1_restart <= i_restart;
        end
        if (load2) begin
            r_s2_err     <= n_err;
            r_s2_mag     <= n_mag;
            r_s2_prod    <= n_prod;
            r_s2_restart <= r_s1_restart;
        end
        if (load3) begin
            r_s3_err     <= r_s2_err;
            r_s3_pterm   <= n_pterm;
            r_s3_integ   <= n_integ1;
            r_s3_active  <= n_active;
            r_s3_settled <= n_settled1;
        end
        if (load4) begin
            r_s4_err     <= r_s3_err;
            r_s4_pterm   <= r_s3_pterm;
            r_s4_iprod   <= n_iprod;
            r_s4_active  <= r_s3_active;
            r_s4_settled <= r_s3_settled;
        end
        if (load_out) begin
            r_out_drive   <= n_drive;
            r_out_err     <= r_s4_err;
            r_out_settled <= r_s4_settled;
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_TARGET: prdata = DATA_W'(r_target);
            REG_TOL:    prdata = DATA_W'(r_tol);
            REG_KP:     prdata = DATA_W'(r_kp);
            REG_KI:     prdata = DATA_W'(r_ki);
            REG_FLOOR:  prdata = DATA_W'(r_floor);
            REG_CEIL:   prdata = DATA_W'(r_ceil);
            REG_DWELL:  prdata = DATA_W'(r_dwell_req);
            default:    prdata = '0;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_drive     = r_out_drive;
    assign o_error_out = r_out_err;
    assign o_settled   = r_out_settled;

    `PIPC_ASSERT_NEXT(a_dwell_monotonic, !(load3 && r_s2_restart),
        r_dwell >= $past(r_dwell), "dwell count dropped without restart")
    `PIPC_ASSERT_NEXT(a_state_frozen, r_settled && !(load3 && r_s2_restart),
        $stable(r_integ) && $stable(r_dwell) && r_settled, "state moved while settled")
    `PIPC_ASSERT_ALWAYS(a_settle_dwell, !$rose(r_settled) || (r_dwell >= r_dwell_req),
        "settled without enough dwell")
    `PIPC_ASSERT_NEXT(a_settled_zero_drive, load_out && !r_s4_active,
        (o_drive == '0) && o_settled, "drive not zero for settled beat")

endmodule
